// ===== design/pta_pkg.sv =====
package pta_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_WINDUP_GAIN = 3'd3,
        CFG_OUT_LIMIT   = 3'd4
    } t_cfg_idx;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Divider retires two quotient bits per cycle over 48 bits
    localparam int unsigned DIV_QBITS = 48;
    localparam int unsigned DIV_STEPS = DIV_QBITS / 2;
    localparam int unsigned DIV_CNT_W = 5;

    // Largest derivative magnitude, 2^47 - 1
    localparam logic [46:0] D_MAX = {47{1'b1}};

    typedef struct packed {
        logic               kind;
        logic signed [31:0] err_in;
        logic        [31:0] step_time;
        logic signed [31:0] feed_fwd;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clamped;
        logic               zero_step;
    } t_out_item;

    // Operand pair selected for the shared multiplier
    typedef enum logic [2:0] {
        MOP_KD_DIFF = 3'd0,
        MOP_KP_ERR  = 3'd1,
        MOP_KI_HALF = 3'd2,
        MOP_QH_DT   = 3'd3,
        MOP_QL_DT   = 3'd4,
        MOP_KAW_EH  = 3'd5,
        MOP_KAW_EL  = 3'd6
    } t_mop;

    typedef struct packed {
        logic in_ready;
        t_mop mop;
        logic div_start;
        logic take_p;
        logic take_ql;
        logic take_inc;
        logic add_inc;
        logic take_isum;
        logic take_integ;
        logic take_sum;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_clear;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

// ===== design/pta_in_if.sv =====
interface pta_in_if;
    logic               valid;
    logic               ready;
    pta_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/pta_out_if.sv =====
interface pta_out_if;
    logic               valid;
    logic               ready;
    pta_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/pta_div.sv =====
module pta_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_mag,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [46:0] o_quo
);

    logic                          r_busy;
    logic                          r_ovf;
    logic [pta_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [31:0]                   r_rem;
    logic [47:0]                   r_num;
    logic [47:0]                   r_quo;
    logic [31:0]                   r_den_w;

    logic [32:0] n_t1;
    logic [32:0] n_t2;
    logic [31:0] n_r1;
    logic [31:0] n_r2;
    logic        n_q1;
    logic        n_q2;
    logic        n_ovf;

    // Quotient of (mag * 256) / den reaches 2^47 exactly when mag / 2^39 >= den
    assign n_ovf = ({7'b0, i_mag[63:39]} >= i_den);

    // Two restoring steps per cycle
    always_comb begin
        n_t1 = {r_rem, r_num[47]};
        n_q1 = (n_t1 >= {1'b0, r_den_w});
        n_r1 = n_q1 ? 32'(n_t1 - {1'b0, r_den_w}) : n_t1[31:0];
        n_t2 = {n_r1, r_num[46]};
        n_q2 = (n_t2 >= {1'b0, r_den_w});
        n_r2 = n_q2 ? 32'(n_t2 - {1'b0, r_den_w}) : n_t2[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= !n_ovf;
            r_cnt  <= pta_pkg::DIV_CNT_W'(pta_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == pta_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Load the operands, then shift in quotient bits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ovf   <= n_ovf;
            r_den_w <= i_den;
            r_rem   <= {8'b0, i_mag[63:40]};
            r_num   <= {i_mag[39:0], 8'b0};
            r_quo   <= '0;
        end else if (r_busy) begin
            r_rem   <= n_r2;
            r_num   <= {r_num[45:0], 2'b00};
            r_quo   <= {r_quo[45:0], n_q1, n_q2};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_ovf ? pta_pkg::D_MAX : r_quo[46:0];

endmodule

// ===== design/pta_ctrl.sv =====
module pta_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pta_pkg::t_sts i_sts,
    output pta_pkg::t_cmd o_cmd
);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b0000_0000_0001,
        ST_MD    = 12'b0000_0000_0010,
        ST_MP    = 12'b0000_0000_0100,
        ST_MI    = 12'b0000_0000_1000,
        ST_MQH   = 12'b0000_0001_0000,
        ST_MQL   = 12'b0000_0010_0000,
        ST_MAH   = 12'b0000_0100_0000,
        ST_MAL   = 12'b0000_1000_0000,
        ST_SAT   = 12'b0001_0000_0000,
        ST_DWAIT = 12'b0010_0000_0000,
        ST_SUM   = 12'b0100_0000_0000,
        ST_FIN   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.mop = pta_pkg::MOP_KD_DIFF;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.in_valid) begin
                    n_state = i_sts.in_clear ? ST_FIN : ST_MD;
                end
            end
            ST_MD: begin
                o_cmd.mop = pta_pkg::MOP_KD_DIFF;
                n_state   = ST_MP;
            end
            ST_MP: begin
                o_cmd.mop       = pta_pkg::MOP_KP_ERR;
                o_cmd.div_start = 1'b1;
                n_state         = ST_MI;
            end
            ST_MI: begin
                o_cmd.mop    = pta_pkg::MOP_KI_HALF;
                o_cmd.take_p = 1'b1;
                n_state      = ST_MQH;
            end
            ST_MQH: begin
                o_cmd.mop     = pta_pkg::MOP_QH_DT;
                o_cmd.take_ql = 1'b1;
                n_state       = ST_MQL;
            end
            ST_MQL: begin
                o_cmd.mop      = pta_pkg::MOP_QL_DT;
                o_cmd.take_inc = 1'b1;
                n_state        = ST_MAH;
            end
            ST_MAH: begin
                o_cmd.mop     = pta_pkg::MOP_KAW_EH;
                o_cmd.add_inc = 1'b1;
                n_state       = ST_MAL;
            end
            ST_MAL: begin
                o_cmd.mop       = pta_pkg::MOP_KAW_EL;
                o_cmd.take_isum = 1'b1;
                n_state         = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.take_integ = 1'b1;
                n_state          = ST_DWAIT;
            end
            ST_DWAIT: begin
                if (i_sts.div_done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                o_cmd.take_sum = 1'b1;
                n_state        = ST_FIN;
            end
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/pta_dpath.sv =====
module pta_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pta_pkg::t_cmd                      i_cmd,
    output pta_pkg::t_sts                      o_sts,
    pta_in_if.sink                             i_in,
    pta_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [pta_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pta_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Configuration
    logic signed [31:0] r_kp;
    logic signed [31:0] r_ki;
    logic signed [31:0] r_kd;
    logic signed [31:0] r_kaw;
    logic        [30:0] r_lim;

    // Latched item
    logic               r_kind;
    logic signed [31:0] r_e;
    logic        [31:0] r_dt;
    logic signed [31:0] r_ff;

    // Controller state carried between items
    logic signed [31:0] r_acc;
    logic signed [31:0] r_last;
    logic signed [47:0] r_exc;

    // Working registers
    logic signed [65:0] r_prod;
    logic signed [47:0] r_p;
    logic        [23:0] r_ql;
    logic signed [57:0] r_inc;
    logic signed [65:0] r_isum;
    logic signed [31:0] r_integ;
    logic               r_dneg;
    logic signed [49:0] r_sum;

    // Output register
    logic               r_ovalid;
    logic signed [31:0] r_drive;
    logic               r_clamped;
    logic               r_zs;

    logic signed [32:0] n_diff;
    logic        [32:0] n_hsum;
    logic signed [32:0] n_mul_a;
    logic signed [32:0] n_mul_b;
    logic        [65:0] n_prod_neg;
    logic        [63:0] n_mag;
    logic signed [65:0] n_isum;
    logic signed [66:0] n_ipre;
    logic signed [31:0] n_integ;
    logic        [46:0] n_quo;
    logic               n_div_busy;
    logic signed [47:0] n_d;
    logic               n_zs;
    logic signed [49:0] n_sum;
    logic signed [49:0] n_lim;
    logic signed [49:0] n_drv;
    logic               n_clamp;
    logic signed [50:0] n_excf;
    logic signed [47:0] n_exc;
    logic               n_out_free;

    assign n_out_free = !r_ovalid || o_out.ready;

    assign i_in.ready = i_cmd.in_ready;
    assign o_sts.in_valid = i_in.valid;
    assign o_sts.in_clear = i_in.payload.kind;
    assign o_sts.div_done = !n_div_busy;
    assign o_sts.out_free = n_out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp  <= '0;
            r_ki  <= '0;
            r_kd  <= '0;
            r_kaw <= '0;
            r_lim <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pta_pkg::CFG_PROP_GAIN:   r_kp  <= i_cfg_data;
                pta_pkg::CFG_INTEG_GAIN:  r_ki  <= i_cfg_data;
                pta_pkg::CFG_DERIV_GAIN:  r_kd  <= i_cfg_data;
                pta_pkg::CFG_WINDUP_GAIN: r_kaw <= i_cfg_data;
                pta_pkg::CFG_OUT_LIMIT:   r_lim <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.payload.kind;
            r_e    <= i_in.payload.err_in;
            r_dt   <= i_in.payload.step_time;
            r_ff   <= i_in.payload.feed_fwd;
        end
    end

    // Select multiplier operands
    always_comb begin
        n_diff = {r_e[31], r_e} - {r_last[31], r_last};
        n_hsum = {r_e[31], r_e} + {r_last[31], r_last};
        unique case (i_cmd.mop)
            pta_pkg::MOP_KD_DIFF: begin
                n_mul_a = {r_kd[31], r_kd};
                n_mul_b = n_diff;
            end
            pta_pkg::MOP_KP_ERR: begin
                n_mul_a = {r_kp[31], r_kp};
                n_mul_b = {r_e[31], r_e};
            end
            pta_pkg::MOP_KI_HALF: begin
                n_mul_a = {r_ki[31], r_ki};
                n_mul_b = {n_hsum[32], n_hsum[32:1]};
            end
            pta_pkg::MOP_QH_DT: begin
                n_mul_a = {{9{r_prod[63]}}, r_prod[63:40]};
                n_mul_b = {1'b0, r_dt};
            end
            pta_pkg::MOP_QL_DT: begin
                n_mul_a = {9'b0, r_ql};
                n_mul_b = {1'b0, r_dt};
            end
            pta_pkg::MOP_KAW_EH: begin
                n_mul_a = {r_kaw[31], r_kaw};
                n_mul_b = {r_exc[47], r_exc[47:16]};
            end
            pta_pkg::MOP_KAW_EL: begin
                n_mul_a = {r_kaw[31], r_kaw};
                n_mul_b = {17'b0, r_exc[15:0]};
            end
            default: begin
                n_mul_a = '0;
                n_mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 66'(n_mul_a) * 66'(n_mul_b);
    end

    // Derivative magnitude for the divider
    assign n_prod_neg = -r_prod;
    assign n_mag      = r_prod[65] ? n_prod_neg[63:0] : r_prod[63:0];

    pta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (n_mag),
        .i_den   (r_dt),
        .o_busy  (n_div_busy),
        .o_quo   (n_quo)
    );

    // Integral: acc + inc - aw, then saturate to 32 bits
    assign n_isum = {{34{r_acc[31]}}, r_acc} + {{8{r_inc[57]}}, r_inc} - r_prod;
    assign n_ipre = {r_isum[65], r_isum} - {{35{r_prod[47]}}, r_prod[47:16]};

    always_comb begin
        if (n_ipre[66:31] == {36{n_ipre[66]}}) begin
            n_integ = n_ipre[31:0];
        end else begin
            n_integ = n_ipre[66] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
        end
    end

    // Derivative sign and zero-step drop
    assign n_zs = (r_dt == '0);
    always_comb begin
        if (n_zs) begin
            n_d = '0;
        end else if (r_dneg) begin
            n_d = -{1'b0, n_quo};
        end else begin
            n_d = {1'b0, n_quo};
        end
    end

    assign n_sum = {{2{r_p[47]}}, r_p} + {{18{r_integ[31]}}, r_integ}
                 + {{2{n_d[47]}}, n_d} + {{18{r_ff[31]}}, r_ff};

    // Clamp and compute the excess
    assign n_lim = {19'b0, r_lim};
    always_comb begin
        if (r_sum > n_lim) begin
            n_drv   = n_lim;
            n_clamp = 1'b1;
        end else if (r_sum < -n_lim) begin
            n_drv   = -n_lim;
            n_clamp = 1'b1;
        end else begin
            n_drv   = r_sum;
            n_clamp = 1'b0;
        end
        n_excf = {r_sum[49], r_sum} - {n_drv[49], n_drv};
        if (n_excf[50:47] == {4{n_excf[50]}}) begin
            n_exc = n_excf[47:0];
        end else begin
            n_exc = n_excf[50] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
        end
    end

    // Advance the working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_dneg <= r_prod[65];
        end
        if (i_cmd.take_p) begin
            r_p <= r_prod[63:16];
        end
        if (i_cmd.take_ql) begin
            r_ql <= r_prod[39:16];
        end
        if (i_cmd.take_inc) begin
            r_inc <= {r_prod[56], r_prod[56:0]};
        end
        if (i_cmd.add_inc) begin
            r_inc <= r_inc + {26'b0, r_prod[55:24]};
        end
        if (i_cmd.take_isum) begin
            r_isum <= n_isum;
        end
        if (i_cmd.take_integ) begin
            r_integ <= n_integ;
        end
        if (i_cmd.take_sum) begin
            r_sum <= n_sum;
        end
    end

    // Update stored state on finish
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_last <= '0;
            r_exc  <= '0;
        end else if (i_cmd.finish) begin
            if (r_kind) begin
                r_acc  <= '0;
                r_last <= '0;
                r_exc  <= '0;
            end else begin
                r_acc  <= r_integ;
                r_last <= r_e;
                r_exc  <= n_exc;
            end
        end
    end

    // Hold the result until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_kind) begin
                r_drive   <= '0;
                r_clamped <= 1'b0;
                r_zs      <= 1'b0;
            end else begin
                r_drive   <= n_drv[31:0];
                r_clamped <= n_clamp;
                r_zs      <= n_zs;
            end
        end
    end

    assign o_out.valid             = r_ovalid;
    assign o_out.payload.drive     = r_drive;
    assign o_out.payload.clamped   = r_clamped;
    assign o_out.payload.zero_step = r_zs;

endmodule

// ===== design/pid_trapezoid_antiwindup_top.sv =====
// Compute item: taken in idle, then multiply states, divider wait, sum and finish;
// finish registers the output once it is free, then the next item is taken.
// Clear item: straight from idle to finish. Compute time is set by the radix-4
// derivative divider, beside one shared 33x33 multiplier for seven operand pairs.
// Reset (synchronous, active low) zeroes gains and stored state, limit to max.
module pid_trapezoid_antiwindup_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pta_in_if.sink                             i_in,
    pta_out_if.source                          o_out,
    input  logic                               i_cfg_we,
    input  logic [pta_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pta_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pta_pkg::t_cmd n_cmd;
    pta_pkg::t_sts n_sts;

    pta_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (n_sts),
        .o_cmd   (n_cmd)
    );

    pta_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (n_cmd),
        .o_sts      (n_sts),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

endmodule

// ===== dv/pid_trapezoid_antiwindup_chk.sv =====
module pid_trapezoid_antiwindup_chk
    import pta_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pta_in_if                     i_in,
    pta_out_if                    i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    typedef logic signed [127:0] t_wide;

    // Gains and limit as the block holds them
    t_wide prop_k, integ_k, deriv_k, windup_k, limit_q;
    // Loop state carried between control steps
    t_wide integ_acc, prev_err, excess;

    t_out_item drive_q[$];

    function automatic t_wide clip(t_wide x, int bits);
        t_wide hi;
        hi = (t_wide'(1) <<< (bits - 1)) - 1;
        if (x > hi) return hi;
        if (x < -hi - 1) return -hi - 1;
        return x;
    endfunction

    // Advance the regulator by one item and return its output
    function automatic t_out_item regulate(t_in_item it);
        t_out_item r;
        t_wide e, ff, dts, p, h, q, inc, aw, integ, d, sum, drv, prod, mag, quo;
        r = '0;
        if (it.kind) begin
            integ_acc = 0;
            prev_err  = 0;
            excess    = 0;
            return r;
        end
        e   = t_wide'($signed(it.err_in));
        ff  = t_wide'($signed(it.feed_fwd));
        dts = t_wide'({96'd0, it.step_time});
        p   = (prop_k * e) >>> 16;
        h   = (e + prev_err) >>> 1;
        q   = (integ_k * h) >>> 16;
        inc = (q * dts) >>> 24;
        aw  = (windup_k * excess) >>> 16;
        integ = clip(integ_acc + inc - aw, 32);
        if (dts == 0) begin
            d = 0;
            r.zero_step = 1'b1;
        end else begin
            prod = deriv_k * (e - prev_err);
            mag  = (prod < 0) ? -prod : prod;
            quo  = (mag <<< 8) / dts;
            if (quo > t_wide'({81'd0, D_MAX})) quo = t_wide'({81'd0, D_MAX});
            d = (prod < 0) ? -quo : quo;
        end
        sum = p + integ + d + ff;
        drv = sum;
        if (sum > limit_q) begin
            drv = limit_q;
            r.clamped = 1'b1;
        end else if (sum < -limit_q) begin
            drv = -limit_q;
            r.clamped = 1'b1;
        end
        integ_acc = integ;
        prev_err  = e;
        excess    = clip(sum - drv, 48);
        r.drive   = drv[31:0];
        return r;
    endfunction

    // Track config, predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            prop_k = 0; integ_k = 0; deriv_k = 0; windup_k = 0;
            limit_q = 128'sh7FFF_FFFF;
            integ_acc = 0; prev_err = 0; excess = 0;
            drive_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROP_GAIN:   prop_k   = t_wide'($signed(i_cfg_data));
                    CFG_INTEG_GAIN:  integ_k  = t_wide'($signed(i_cfg_data));
                    CFG_DERIV_GAIN:  deriv_k  = t_wide'($signed(i_cfg_data));
                    CFG_WINDUP_GAIN: windup_k = t_wide'($signed(i_cfg_data));
                    CFG_OUT_LIMIT:   limit_q  = t_wide'({97'd0, i_cfg_data[30:0]});
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) drive_q.push_back(regulate(i_in.payload));
            if (i_out.valid && i_out.ready) begin
                if (drive_q.size() == 0) begin
                    $error("unexpected output transfer, drive %h", i_out.payload.drive);
                    o_errors++;
                end else begin
                    want = drive_q.pop_front();
                    if (i_out.payload.drive !== want.drive) begin
                        $error("drive: expected %h, got %h", want.drive,
                               i_out.payload.drive);
                        o_errors++;
                    end
                    if (i_out.payload.clamped !== want.clamped) begin
                        $error("clamped: expected %b, got %b", want.clamped,
                               i_out.payload.clamped);
                        o_errors++;
                    end
                    if (i_out.payload.zero_step !== want.zero_step) begin
                        $error("zero_step: expected %b, got %b", want.zero_step,
                               i_out.payload.zero_step);
                        o_errors++;
                    end
                end
            end
        end
        o_pending = drive_q.size();
    end

endmodule

// ===== dv/pid_trapezoid_antiwindup_top_tb.sv =====
module pid_trapezoid_antiwindup_top_tb;
    import pta_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    bit                    quiet;
    bit                    hold_req;

    pta_in_if  in_ch ();
    pta_out_if out_ch ();

    pid_trapezoid_antiwindup_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    pid_trapezoid_antiwindup_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .i_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Result side: random stalls, a quiet stretch, and one long hold-off on request
    initial begin
        int hold;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && hold == 0) begin
                hold = 400;
                hold_req = 1'b0;
            end
            if (hold > 0) begin
                out_ch.ready = 1'b0;
                hold--;
            end else begin
                out_ch.ready = quiet ? 1'b1 : ($urandom_range(99) >= 31);
            end
        end
    end

    // Wait for all results, then let the block settle before touching config
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic write_gains(logic [31:0] kp, logic [31:0] ki, logic [31:0] kd,
                               logic [31:0] kaw, logic [31:0] lim);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_WINDUP_GAIN, kaw);
        write_reg(CFG_OUT_LIMIT, lim);
    endtask

    // Offer one item at a falling edge and hold it until the transfer
    task automatic send(logic kind, logic [31:0] e, logic [31:0] dt, logic [31:0] ff);
        if (!quiet && $urandom_range(99) < 31) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        in_ch.valid           = 1'b1;
        in_ch.payload.kind    = kind;
        in_ch.payload.err_in  = e;
        in_ch.payload.step_time = dt;
        in_ch.payload.feed_fwd  = ff;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return $urandom;
            default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic logic [31:0] pick_signal();
        if ($urandom_range(2) == 0) return $urandom;
        return 32'($signed($urandom_range(200 << 16)) - (100 << 16));
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(9))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(32'h0100_0000, 32'h0000_1000);
        endcase
    endfunction

    initial begin
        logic [31:0] lim;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_PROP_GAIN;
        cfg_data = '0;
        quiet    = 1'b0;
        hold_req = 1'b0;
        i_rst_n  = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset gains first, then moderate gains over field extremes
        send(1'b0, 32'h0001_0000, 32'h0100_0000, 32'h0000_8000);
        drain();
        write_gains(32'h0001_0000, 32'h0000_8000, 32'h0000_0100, 32'h0000_4000,
                    32'h0064_0000);
        write_reg(CFG_IDX_W'(CFG_OUT_LIMIT) + 1'b1, 32'hFFFF_FFFF);
        send(1'b0, 32'h7FFF_FFFF, 32'h0100_0000, 32'h0);
        send(1'b0, 32'h8000_0000, 32'h0100_0000, 32'h0);
        send(1'b0, 32'h0001_0000, 32'h0, 32'h0);
        send(1'b0, 32'h0002_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send(1'b0, 32'hFFFF_0000, 32'h0000_0001, 32'h8000_0000);
        send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(1'b0, 32'h0000_0000, 32'h0, 32'h0);
        send(1'b0, 32'h0050_0000, 32'h0010_0000, 32'h0040_0000);
        send(1'b0, 32'h0050_0000, 32'h0010_0000, 32'h0040_0000);
        send(1'b0, 32'hFFB0_0000, 32'h0010_0000, 32'hFFC0_0000);
        drain();
        write_gains(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0);
        send(1'b0, 32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        send(1'b0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        send(1'b0, 32'h8000_0000, 32'h0, 32'h0);
        send(1'b0, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0);
        drain();
        write_gains(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF);
        send(1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send(1'b0, 32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
        send(1'b1, 32'h0, 32'h0, 32'h0);

        // Random phases, each under a fresh setting
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            quiet = (ph == 3);
            lim = (ph == 1) ? 32'h0 : (ph == 4) ? 32'h7FFF_FFFF
                : $urandom_range(32'h0200_0000, 32'h0001_0000);
            write_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), lim);
            if (ph == 2) hold_req = 1'b1;
            for (int n = 0; n < 150; n++) begin
                send($urandom_range(19) == 0, pick_signal(), pick_step(), pick_signal());
            end
        end
        in_ch.valid = 1'b0;
        quiet = 1'b0;

        drain();
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(12 * 2_000_000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
